[rtl/core/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg: shared definitions for the address region map
// Defaults, request codes, register indexes and the cell control types.
// ----------------------------------------------------------------------------
package arm_pkg;

    localparam int MAX_REGIONS_DEF = 64;
    localparam int PAGE_SHIFT_DEF  = 12;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int OBJECT_BITS_DEF = 16;

    localparam int TYPE_BITS       = 3;
    localparam int BYTE_FIELD_BITS = 8;
    localparam int OFFSET_BITS     = 64;
    localparam int PDATA_BITS      = 64;
    localparam int PADDR_BITS      = 4;
    localparam int REG_SEL_BIT     = 3;

    localparam logic [63:0] WINDOW_CEILING_RESET = 64'h0000_FFFF_FFFF_F000;

    localparam logic [TYPE_BITS-1:0] REQ_ENTER  = 3'd0;
    localparam logic [TYPE_BITS-1:0] REQ_REMOVE = 3'd1;
    localparam logic [TYPE_BITS-1:0] REQ_LOOKUP = 3'd2;
    localparam logic [TYPE_BITS-1:0] REQ_FIND   = 3'd3;
    localparam logic [TYPE_BITS-1:0] REQ_CLEAR  = 3'd4;

    localparam logic REG_FLOOR   = 1'b0;
    localparam logic REG_CEILING = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_COMPACT,
        CELL_ROTATE
    } cell_mode_t;

    typedef struct packed {
        logic ge;
        logic ovl;
        logic hit;
    } cell_flags_t;

    typedef struct packed {
        logic ins;
        logic drop;
        logic hit;
        logic ovl;
    } cell_link_t;

endpackage

[rtl/core/arm_cell.sv]
// ----------------------------------------------------------------------------
// arm_cell: one region slot of the map chain
// Holds one region, compares it against the request key and moves data
// to or from its neighbors for insert, compaction and rotation.
// ----------------------------------------------------------------------------
module arm_cell #(
    parameter int ADDR_BITS   = arm_pkg::ADDR_BITS_DEF,
    parameter int OBJECT_BITS = arm_pkg::OBJECT_BITS_DEF,
    localparam int RW = 2 * ADDR_BITS + 2 * arm_pkg::BYTE_FIELD_BITS + OBJECT_BITS
                        + arm_pkg::OFFSET_BITS
) (
    input  logic                 aclk,
    input  arm_pkg::cell_mode_t  mode,
    input  logic                 valid,
    input  logic [ADDR_BITS-1:0] key_addr,
    input  logic [ADDR_BITS:0]   key_end,
    input  logic [RW-1:0]        new_data,
    input  logic [RW-1:0]        left_data,
    input  logic [RW-1:0]        right_data,
    input  logic [RW-1:0]        gather_in,
    input  arm_pkg::cell_link_t  link_in,
    output arm_pkg::cell_link_t  link_out,
    output logic [RW-1:0]        gather_out,
    output logic [RW-1:0]        data_out
);

    logic [RW-1:0]        data_reg;
    logic [RW-1:0]        data_next;
    arm_pkg::cell_flags_t flags_reg;
    arm_pkg::cell_flags_t flags_next;
    logic [ADDR_BITS-1:0] start_w;
    logic [ADDR_BITS-1:0] stop_w;
    logic                 inside_w;

    assign start_w  = data_reg[RW-1 -: ADDR_BITS];
    assign stop_w   = data_reg[RW-ADDR_BITS-1 -: ADDR_BITS];
    assign data_out = data_reg;

    always_comb begin
        flags_next.ge  = start_w >= key_addr;
        flags_next.ovl = ({1'b0, start_w} < key_end) && (stop_w > key_addr);
        flags_next.hit = (start_w <= key_addr) && (stop_w > key_addr);
        inside_w       = (start_w >= key_addr) && ({1'b0, stop_w} <= key_end);
    end

    always_comb begin
        link_out.ins  = !valid || flags_reg.ge;
        link_out.drop = link_in.drop || (valid && inside_w);
        link_out.hit  = link_in.hit || (valid && flags_reg.hit);
        link_out.ovl  = link_in.ovl || (valid && flags_reg.ovl);
        gather_out    = gather_in | ((valid && flags_reg.hit) ? data_reg : '0);
    end

    always_comb begin
        data_next = data_reg;
        case (mode)
            arm_pkg::CELL_INSERT: begin
                if (link_in.ins) begin
                    data_next = left_data;
                end else if (link_out.ins) begin
                    data_next = new_data;
                end
            end
            arm_pkg::CELL_COMPACT: begin
                if (link_out.drop) begin
                    data_next = right_data;
                end
            end
            arm_pkg::CELL_ROTATE: begin
                data_next = right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        flags_reg <= flags_next;
    end

endmodule

[rtl/core/address_region_map.sv]
// ----------------------------------------------------------------------------
// address_region_map: sorted table of address regions in a map window
// Enter, remove, lookup, next-fit find_space and clear over a chain of
// region cells; window floor and ceiling set over the APB port.
//
//   channel   dir   handshake          payload
//   s_*       in    s_valid/s_ready    request type, address, length, attributes
//   m_*       out   m_valid/m_ready    status, found region, counts
//   apb       in    psel/penable       window_floor (0x0), window_ceiling (0x8)
//
// Enter, lookup, clear: result offered after the EVAL, DECIDE and DONE states.
// Remove: adds ST_COMPACT, one shift step of the chain per dropped region, before DONE.
// Find_space: a full rotation of the chain through ST_SEARCH per pass, up to
// two passes, each pass closed by ST_SEARCH_END.
// One request in flight; a result held by m_ready low stalls only the next
// request's completion. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module address_region_map #(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
    parameter int PAGE_SHIFT  = arm_pkg::PAGE_SHIFT_DEF,
    parameter int ADDR_BITS   = arm_pkg::ADDR_BITS_DEF,
    parameter int OBJECT_BITS = arm_pkg::OBJECT_BITS_DEF,
    localparam int CW = $clog2(MAX_REGIONS + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [arm_pkg::TYPE_BITS-1:0]     s_req_type,
    input  logic [ADDR_BITS-1:0]              s_address,
    input  logic [ADDR_BITS-1:0]              s_length,
    input  logic [arm_pkg::BYTE_FIELD_BITS-1:0] s_access_bits,
    input  logic [arm_pkg::BYTE_FIELD_BITS-1:0] s_attr_bits,
    input  logic [OBJECT_BITS-1:0]            s_object_handle,
    input  logic [arm_pkg::OFFSET_BITS-1:0]   s_backing_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [ADDR_BITS-1:0]              m_found_address,
    output logic [ADDR_BITS-1:0]              m_found_end,
    output logic [arm_pkg::BYTE_FIELD_BITS-1:0] m_found_access,
    output logic [arm_pkg::BYTE_FIELD_BITS-1:0] m_found_attr,
    output logic [OBJECT_BITS-1:0]            m_found_object,
    output logic [arm_pkg::OFFSET_BITS-1:0]   m_found_offset,
    output logic [CW-1:0]                     m_removed_count,
    output logic [CW-1:0]                     m_regions_held,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [arm_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [arm_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [arm_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready
);

    localparam int BW = arm_pkg::BYTE_FIELD_BITS;
    localparam int OW = arm_pkg::OFFSET_BITS;
    localparam int RW = 2 * ADDR_BITS + 2 * BW + OBJECT_BITS + OW;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam bit SAT_ON = (ADDR_BITS == 64);
    localparam logic [ADDR_BITS-1:0] CEIL_RESET =
        ADDR_BITS'(arm_pkg::WINDOW_CEILING_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_COMPACT,
        ST_SEARCH,
        ST_SEARCH_END,
        ST_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               total_reg, total_next;
    logic [ADDR_BITS-1:0]        hint_reg, hint_next;
    logic [ADDR_BITS-1:0]        floor_reg, floor_next;
    logic [ADDR_BITS-1:0]        ceil_reg, ceil_next;

    logic [arm_pkg::TYPE_BITS-1:0] req_type_reg, req_type_next;
    logic [ADDR_BITS-1:0]        addr_reg, addr_next;
    logic [ADDR_BITS-1:0]        len_reg, len_next;
    logic [BW-1:0]               access_reg, access_next;
    logic [BW-1:0]               attr_reg, attr_next;
    logic [OBJECT_BITS-1:0]      object_reg, object_next;
    logic [OW-1:0]               offset_reg, offset_next;

    logic [ADDR_BITS:0]          size_reg, size_next;
    logic [ADDR_BITS-1:0]        cur_reg, cur_next;
    logic [IW-1:0]               step_reg, step_next;
    logic                        brk_reg, brk_next;
    logic                        second_reg, second_next;

    logic                        res_ok_reg, res_ok_next;
    logic [ADDR_BITS-1:0]        res_addr_reg, res_addr_next;
    logic [ADDR_BITS-1:0]        res_end_reg, res_end_next;
    logic [BW-1:0]               res_access_reg, res_access_next;
    logic [BW-1:0]               res_attr_reg, res_attr_next;
    logic [OBJECT_BITS-1:0]      res_object_reg, res_object_next;
    logic [OW-1:0]               res_offset_reg, res_offset_next;
    logic [CW-1:0]               res_removed_reg, res_removed_next;

    logic                        m_valid_reg, m_valid_next;
    logic                        m_ok_reg, m_ok_next;
    logic [ADDR_BITS-1:0]        m_addr_reg, m_addr_next;
    logic [ADDR_BITS-1:0]        m_end_reg, m_end_next;
    logic [BW-1:0]               m_access_reg, m_access_next;
    logic [BW-1:0]               m_attr_reg, m_attr_next;
    logic [OBJECT_BITS-1:0]      m_object_reg, m_object_next;
    logic [OW-1:0]               m_offset_reg, m_offset_next;
    logic [CW-1:0]               m_removed_reg, m_removed_next;
    logic [CW-1:0]               m_held_reg, m_held_next;

    arm_pkg::cell_mode_t         mode;
    logic [ADDR_BITS:0]          end_sum;
    logic [ADDR_BITS:0]          key_end;
    logic [ADDR_BITS:0]          size_round;
    logic [ADDR_BITS:0]          size_calc;
    logic                        size_fail;
    logic [ADDR_BITS+1:0]        cur_sum;
    logic [ADDR_BITS+1:0]        cur_sat;
    logic [ADDR_BITS-1:0]        start0;
    logic [ADDR_BITS-1:0]        stop0;
    logic [RW-1:0]               new_data;
    logic                        enter_ok;
    logic                        fit;
    logic                        cfg_wr;

    logic [RW-1:0]               data_w   [MAX_REGIONS];
    logic [RW-1:0]               gather_w [MAX_REGIONS+1];
    arm_pkg::cell_link_t         link_w   [MAX_REGIONS+1];
    logic [MAX_REGIONS-1:0]      cell_valid;

    assign pready = 1'b1;
    assign prdata = (paddr[arm_pkg::REG_SEL_BIT] == arm_pkg::REG_CEILING) ?
                    arm_pkg::PDATA_BITS'(ceil_reg) : arm_pkg::PDATA_BITS'(floor_reg);
    assign cfg_wr = psel && penable && pwrite;

    assign end_sum    = {1'b0, addr_reg} + {1'b0, len_reg};
    assign key_end    = (SAT_ON && end_sum[ADDR_BITS]) ? {1'b0, {ADDR_BITS{1'b1}}} : end_sum;
    assign size_round = {1'b0, len_reg} + (ADDR_BITS+1)'({PAGE_SHIFT{1'b1}});
    assign size_calc  = {size_round[ADDR_BITS:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign size_fail  = SAT_ON && size_round[ADDR_BITS];
    assign cur_sum    = {2'b00, cur_reg} + {1'b0, size_reg};
    assign cur_sat    = (SAT_ON && (cur_sum[ADDR_BITS+1:ADDR_BITS] != 2'b00)) ?
                        {2'b00, {ADDR_BITS{1'b1}}} : cur_sum;
    assign start0     = data_w[0][RW-1 -: ADDR_BITS];
    assign stop0      = data_w[0][RW-ADDR_BITS-1 -: ADDR_BITS];
    assign new_data   = {addr_reg, end_sum[ADDR_BITS-1:0], access_reg, attr_reg,
                         object_reg, offset_reg};
    assign fit        = !(cur_sat > {2'b00, ceil_reg});

    assign enter_ok = (len_reg != '0) && (addr_reg[PAGE_SHIFT-1:0] == '0)
                      && (len_reg[PAGE_SHIFT-1:0] == '0) && !end_sum[ADDR_BITS]
                      && (addr_reg >= floor_reg) && (end_sum <= {1'b0, ceil_reg})
                      && (total_reg < CW'(MAX_REGIONS)) && !link_w[MAX_REGIONS].ovl;

    assign gather_w[0] = '0;
    assign link_w[0]   = '0;

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        localparam int NXT = (i + 1) % MAX_REGIONS;
        localparam int PRV = (i == 0) ? 0 : i - 1;

        assign cell_valid[i] = total_reg > CW'(i);

        arm_cell #(
            .ADDR_BITS   (ADDR_BITS),
            .OBJECT_BITS (OBJECT_BITS)
        ) u_cell (
            .aclk       (aclk),
            .mode       (mode),
            .valid      (cell_valid[i]),
            .key_addr   (addr_reg),
            .key_end    (key_end),
            .new_data   (new_data),
            .left_data  ((i == 0) ? new_data : data_w[PRV]),
            .right_data (data_w[NXT]),
            .gather_in  (gather_w[i]),
            .link_in    (link_w[i]),
            .link_out   (link_w[i+1]),
            .gather_out (gather_w[i+1]),
            .data_out   (data_w[i])
        );
    end

    always_comb begin
        state_next       = state_reg;
        total_next       = total_reg;
        hint_next        = hint_reg;
        floor_next       = floor_reg;
        ceil_next        = ceil_reg;
        req_type_next    = req_type_reg;
        addr_next        = addr_reg;
        len_next         = len_reg;
        access_next      = access_reg;
        attr_next        = attr_reg;
        object_next      = object_reg;
        offset_next      = offset_reg;
        size_next        = size_reg;
        cur_next         = cur_reg;
        step_next        = step_reg;
        brk_next         = brk_reg;
        second_next      = second_reg;
        res_ok_next      = res_ok_reg;
        res_addr_next    = res_addr_reg;
        res_end_next     = res_end_reg;
        res_access_next  = res_access_reg;
        res_attr_next    = res_attr_reg;
        res_object_next  = res_object_reg;
        res_offset_next  = res_offset_reg;
        res_removed_next = res_removed_reg;
        m_valid_next     = m_valid_reg;
        m_ok_next        = m_ok_reg;
        m_addr_next      = m_addr_reg;
        m_end_next       = m_end_reg;
        m_access_next    = m_access_reg;
        m_attr_next      = m_attr_reg;
        m_object_next    = m_object_reg;
        m_offset_next    = m_offset_reg;
        m_removed_next   = m_removed_reg;
        m_held_next      = m_held_reg;
        mode             = arm_pkg::CELL_HOLD;
        s_ready          = (state_reg == ST_IDLE);

        if (cfg_wr) begin
            if (paddr[arm_pkg::REG_SEL_BIT] == arm_pkg::REG_CEILING) begin
                ceil_next = pwdata[ADDR_BITS-1:0];
            end else begin
                floor_next = pwdata[ADDR_BITS-1:0];
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_type_next    = s_req_type;
                    addr_next        = s_address;
                    len_next         = s_length;
                    access_next      = s_access_bits;
                    attr_next        = s_attr_bits;
                    object_next      = s_object_handle;
                    offset_next      = s_backing_offset;
                    res_ok_next      = 1'b0;
                    res_addr_next    = '0;
                    res_end_next     = '0;
                    res_access_next  = '0;
                    res_attr_next    = '0;
                    res_object_next  = '0;
                    res_offset_next  = '0;
                    res_removed_next = '0;
                    state_next       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                size_next   = size_calc;
                cur_next    = (hint_reg < floor_reg) ? floor_reg : hint_reg;
                step_next   = '0;
                brk_next    = 1'b0;
                second_next = 1'b0;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                case (req_type_reg)
                    arm_pkg::REQ_ENTER: begin
                        if (enter_ok) begin
                            mode        = arm_pkg::CELL_INSERT;
                            total_next  = total_reg + CW'(1);
                            res_ok_next = 1'b1;
                        end
                    end
                    arm_pkg::REQ_REMOVE: begin
                        if (len_reg != '0) begin
                            state_next = ST_COMPACT;
                        end
                    end
                    arm_pkg::REQ_LOOKUP: begin
                        res_ok_next     = link_w[MAX_REGIONS].hit;
                        res_addr_next   = gather_w[MAX_REGIONS][RW-1 -: ADDR_BITS];
                        res_end_next    = gather_w[MAX_REGIONS][RW-ADDR_BITS-1 -: ADDR_BITS];
                        res_access_next = gather_w[MAX_REGIONS][OW+OBJECT_BITS+BW +: BW];
                        res_attr_next   = gather_w[MAX_REGIONS][OW+OBJECT_BITS +: BW];
                        res_object_next = gather_w[MAX_REGIONS][OW +: OBJECT_BITS];
                        res_offset_next = gather_w[MAX_REGIONS][OW-1:0];
                    end
                    arm_pkg::REQ_FIND: begin
                        if ((len_reg != '0) && !size_fail) begin
                            state_next = ST_SEARCH;
                        end
                    end
                    arm_pkg::REQ_CLEAR: begin
                        total_next = '0;
                        hint_next  = floor_reg;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_COMPACT: begin
                mode = arm_pkg::CELL_COMPACT;
                if (link_w[MAX_REGIONS].drop) begin
                    total_next       = total_reg - CW'(1);
                    res_removed_next = res_removed_reg + CW'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH: begin
                mode = arm_pkg::CELL_ROTATE;
                if (!brk_reg && (CW'(step_reg) < total_reg) && (stop0 > cur_reg)) begin
                    if ({2'b00, start0} >= cur_sat) begin
                        brk_next = 1'b1;
                    end else begin
                        cur_next = stop0;
                    end
                end
                if (step_reg == IW'(MAX_REGIONS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SEARCH_END;
                end else begin
                    step_next = step_reg + IW'(1);
                end
            end
            ST_SEARCH_END: begin
                if (fit && (cur_reg != '0)) begin
                    hint_next     = cur_sum[ADDR_BITS-1:0];
                    res_ok_next   = 1'b1;
                    res_addr_next = cur_reg;
                    state_next    = ST_DONE;
                end else if (!second_reg && (hint_reg > floor_reg)) begin
                    second_next = 1'b1;
                    cur_next    = floor_reg;
                    brk_next    = 1'b0;
                    step_next   = '0;
                    state_next  = ST_SEARCH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_ok_next      = res_ok_reg;
                    m_addr_next    = res_addr_reg;
                    m_end_next     = res_end_reg;
                    m_access_next  = res_access_reg;
                    m_attr_next    = res_attr_reg;
                    m_object_next  = res_object_reg;
                    m_offset_next  = res_offset_reg;
                    m_removed_next = res_removed_reg;
                    m_held_next    = total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            hint_reg    <= '0;
            floor_reg   <= '0;
            ceil_reg    <= CEIL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            hint_reg    <= hint_next;
            floor_reg   <= floor_next;
            ceil_reg    <= ceil_next;
            m_valid_reg <= m_valid_next;
        end
        req_type_reg    <= req_type_next;
        addr_reg        <= addr_next;
        len_reg         <= len_next;
        access_reg      <= access_next;
        attr_reg        <= attr_next;
        object_reg      <= object_next;
        offset_reg      <= offset_next;
        size_reg        <= size_next;
        cur_reg         <= cur_next;
        step_reg        <= step_next;
        brk_reg         <= brk_next;
        second_reg      <= second_next;
        res_ok_reg      <= res_ok_next;
        res_addr_reg    <= res_addr_next;
        res_end_reg     <= res_end_next;
        res_access_reg  <= res_access_next;
        res_attr_reg    <= res_attr_next;
        res_object_reg  <= res_object_next;
        res_offset_reg  <= res_offset_next;
        res_removed_reg <= res_removed_next;
        m_ok_reg        <= m_ok_next;
        m_addr_reg      <= m_addr_next;
        m_end_reg       <= m_end_next;
        m_access_reg    <= m_access_next;
        m_attr_reg      <= m_attr_next;
        m_object_reg    <= m_object_next;
        m_offset_reg    <= m_offset_next;
        m_removed_reg   <= m_removed_next;
        m_held_reg      <= m_held_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_found_address = m_addr_reg;
    assign m_found_end     = m_end_reg;
    assign m_found_access  = m_access_reg;
    assign m_found_attr    = m_attr_reg;
    assign m_found_object  = m_object_reg;
    assign m_found_offset  = m_offset_reg;
    assign m_removed_count = m_removed_reg;
    assign m_regions_held  = m_held_reg;

endmodule

[rtl/core/arm_checker.sv]
// ----------------------------------------------------------------------------
// arm_checker: port-level checks for the address region map
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module arm_checker #(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = arm_pkg::ADDR_BITS_DEF,
    localparam int CW = $clog2(MAX_REGIONS + 1)
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_ok,
    input logic [ADDR_BITS-1:0] m_found_address,
    input logic [ADDR_BITS-1:0] m_found_end,
    input logic [CW-1:0]        m_removed_count,
    input logic [CW-1:0]        m_regions_held
);

    // one request at a time: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_regions_held))
        else $error("stalled result changed");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_regions_held <= CW'(MAX_REGIONS))
        else $error("region count above table size");

    a_remove_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_removed_count != '0) |-> !m_ok)
        else $error("remove reported ok");

    a_lookup_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ok && (m_found_end != '0) |-> m_found_end > m_found_address)
        else $error("found region is empty or inverted");

endmodule

bind address_region_map arm_checker #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS)
) u_arm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_ok            (m_ok),
    .m_found_address (m_found_address),
    .m_found_end     (m_found_end),
    .m_removed_count (m_removed_count),
    .m_regions_held  (m_regions_held)
);
